// ===== sv/rrq_pkg.sv =====
`timescale 1ns / 1ps
// rrq_pkg: shared types, codes and constants for the record ring queue.
// No dependencies; imported by rrq_front, rrq_back and record_ring_queue.
package rrq_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = 4;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_MAX_RECORD  = 64;
  localparam int CAP_RESET       = 16;
  localparam int LIMIT_RESET     = 64;
  localparam int CMDQ_DEPTH      = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 3'd0,
    KIND_PUSH  = 3'd1,
    KIND_POP   = 3'd2,
    KIND_READ  = 3'd3,
    KIND_DROP  = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY     = 1'b0,
    REG_RECORD_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_REPLY  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_STREAM = 2'd2
  } cmd_op_e;

  typedef enum logic {
    F_ACCEPT = 1'b0,
    F_LEN    = 1'b1
  } f_state_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_RD   = 2'd1,
    B_LOAD = 2'd2
  } b_state_e;

  // One command from the front to the back. len is the reply length or,
  // for a stream, the byte count; off is the byte offset of a write.
  typedef struct packed {
    cmd_op_e           op;
    status_e           status;
    logic              we;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  off;
  } cmd_t;

endpackage

// ===== sv/rrq_cmd_fifo.sv =====
`timescale 1ns / 1ps
// rrq_cmd_fifo: small command queue between the front and back sections.
// Depends on nothing; width and depth come from the top level.
module rrq_cmd_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/rrq_front.sv =====
`timescale 1ns / 1ps
// rrq_front: accepts requests and config writes, keeps the ring pointers and
// record lengths, and issues commands to the back. Uses rrq_pkg.
module rrq_front #(
  parameter int QUEUE_DEPTH = rrq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_RECORD  = rrq_pkg::DEF_MAX_RECORD
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rrq_pkg::KIND_W-1:0]           kind_i,
  input  logic [rrq_pkg::BYTE_W-1:0]           data_byte_i,
  input  logic                                 last_i,
  input  logic [rrq_pkg::IDX_W-1:0]            slot_index_i,
  input  logic [rrq_pkg::LEN_W-1:0]            read_limit_i,
  input  logic                                 cfg_valid_i,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rrq_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output rrq_pkg::cmd_t                        cmd_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       slot_o
);

  import rrq_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
  localparam int CAP_RST = (QUEUE_DEPTH < CAP_RESET) ? QUEUE_DEPTH : CAP_RESET;
  localparam int LIM_RST = (MAX_RECORD < LIMIT_RESET) ? MAX_RECORD : LIMIT_RESET;

  f_state_e         state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d, cap_q, cap_d;
  logic [LEN_W-1:0] fill_q, fill_d, lim_q, lim_d;
  kind_e            pend_kind_q, pend_kind_d;
  logic [LEN_W-1:0] pend_rlim_q, pend_rlim_d;
  logic [PTR_W-1:0] pend_slot_q, pend_slot_d;

  logic [LEN_W-1:0] len_mem_q [QUEUE_DEPTH];
  logic [LEN_W-1:0] len_rdata_q;
  logic             len_we, len_re;
  logic [PTR_W-1:0] len_waddr, len_raddr;

  logic             accept, cfg_we, full, empty, store, idx_ok, need_len;
  kind_e            kind;
  logic [PTR_W-1:0] wslot, head_inc, tail_inc, tail_dec, read_slot;
  logic [LEN_W-1:0] fill_inc, n_w, n_clamp, pop_n;
  logic [SUM_W-1:0] read_sum;

  assign kind       = kind_e'(kind_i);
  assign in_ready_o = (state_q == F_ACCEPT) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cfg_we     = cfg_valid_i;

  assign full     = (count_q >= cap_q);
  assign empty    = (count_q == '0);
  assign head_inc = ((CNT_W'(head_q) + CNT_W'(1)) == cap_q) ? '0 : head_q + PTR_W'(1);
  assign tail_inc = ((CNT_W'(tail_q) + CNT_W'(1)) == cap_q) ? '0 : tail_q + PTR_W'(1);
  assign tail_dec = (tail_q == '0) ? PTR_W'(cap_q - CNT_W'(1)) : tail_q - PTR_W'(1);
  assign wslot    = (kind == KIND_ADD) ? head_q : tail_dec;
  assign store    = (fill_q < lim_q);
  assign fill_inc = store ? fill_q + LEN_W'(1) : fill_q;
  assign n_w      = (fill_inc < lim_q) ? fill_inc : lim_q;

  assign idx_ok = (SUM_W'(slot_index_i) < SUM_W'(count_q));
  always_comb begin
    read_sum = SUM_W'(tail_q) + SUM_W'(slot_index_i);
    if (read_sum >= SUM_W'(cap_q)) begin
      read_sum = read_sum - SUM_W'(cap_q);
    end
  end
  assign read_slot = PTR_W'(read_sum);

  assign need_len = !empty && ((kind == KIND_POP) || (kind == KIND_DROP) ||
                               ((kind == KIND_READ) && idx_ok));

  assign n_clamp = (len_rdata_q > LEN_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD) : len_rdata_q;
  assign pop_n   = ((pend_rlim_q != '0) && (pend_rlim_q < n_clamp)) ? pend_rlim_q : n_clamp;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_ACCEPT: begin
        if (accept && need_len) begin
          state_d = F_LEN;
        end
      end
      F_LEN: begin
        state_d = F_ACCEPT;
      end
    endcase
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    fill_d      = fill_q;
    cap_d       = cap_q;
    lim_d       = lim_q;
    pend_kind_d = pend_kind_q;
    pend_rlim_d = pend_rlim_q;
    pend_slot_d = pend_slot_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    cmd_o.op    = CMD_REPLY;
    cmd_o.status = ST_OK;
    slot_o      = '0;
    len_we      = 1'b0;
    len_waddr   = wslot;
    len_re      = 1'b0;
    len_raddr   = tail_q;

    if (state_q == F_LEN) begin
      push_o = 1'b1;
      slot_o = pend_slot_q;
      unique case (pend_kind_q)
        KIND_POP: begin
          cmd_o.op  = CMD_STREAM;
          cmd_o.len = pop_n;
        end
        KIND_READ: begin
          cmd_o.op  = CMD_STREAM;
          cmd_o.len = n_clamp;
        end
        default: begin
          cmd_o.len = len_rdata_q;
        end
      endcase
    end else if (accept) begin
      unique case (kind)
        KIND_ADD, KIND_PUSH: begin
          push_o = 1'b1;
          if (full) begin
            fill_d       = '0;
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.op   = CMD_WRITE;
            cmd_o.we   = store;
            cmd_o.data = data_byte_i;
            cmd_o.off  = fill_q;
            cmd_o.len  = n_w;
            slot_o     = wslot;
            fill_d     = fill_inc;
            if (last_i) begin
              len_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
              fill_d  = '0;
              if (kind == KIND_ADD) begin
                head_d = head_inc;
              end else begin
                tail_d = wslot;
              end
            end
          end
        end
        KIND_POP, KIND_DROP: begin
          if (empty) begin
            push_o       = 1'b1;
            cmd_o.status = ST_EMPTY;
          end else begin
            len_re      = 1'b1;
            pend_kind_d = kind;
            pend_slot_d = tail_q;
            pend_rlim_d = read_limit_i;
            tail_d      = tail_inc;
            count_d     = count_q - CNT_W'(1);
          end
        end
        KIND_READ: begin
          if (empty) begin
            push_o       = 1'b1;
            cmd_o.status = ST_EMPTY;
          end else if (!idx_ok) begin
            push_o       = 1'b1;
            cmd_o.status = ST_RANGE;
          end else begin
            len_re      = 1'b1;
            len_raddr   = read_slot;
            pend_kind_d = kind;
            pend_slot_d = read_slot;
          end
        end
        KIND_CLEAR: begin
          push_o  = 1'b1;
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
          fill_d  = '0;
        end
        default: begin
        end
      endcase
    end

    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CAPACITY: begin
          if (cfg_data_i[CAP_W-1:0] == '0) begin
            cap_d = CNT_W'(1);
          end else if (32'(cfg_data_i[CAP_W-1:0]) > 32'(QUEUE_DEPTH)) begin
            cap_d = CNT_W'(QUEUE_DEPTH);
          end else begin
            cap_d = CNT_W'(cfg_data_i[CAP_W-1:0]);
          end
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
          fill_d  = '0;
        end
        REG_RECORD_LIMIT: begin
          if (cfg_data_i == '0) begin
            lim_d = LEN_W'(1);
          end else if (cfg_data_i > LEN_W'(MAX_RECORD)) begin
            lim_d = LEN_W'(MAX_RECORD);
          end else begin
            lim_d = cfg_data_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_ACCEPT;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      cap_q       <= CNT_W'(CAP_RST);
      lim_q       <= LEN_W'(LIM_RST);
      pend_kind_q <= KIND_POP;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      cap_q       <= cap_d;
      lim_q       <= lim_d;
      pend_kind_q <= pend_kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_rlim_q <= pend_rlim_d;
    pend_slot_q <= pend_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem_q[len_waddr] <= n_w;
    end
    if (len_re) begin
      len_rdata_q <= len_mem_q[len_raddr];
    end
  end

endmodule

// ===== sv/rrq_back.sv =====
`timescale 1ns / 1ps
// rrq_back: executes commands from the queue against the record byte memory
// and drives the output register. Uses rrq_pkg.
module rrq_back #(
  parameter int QUEUE_DEPTH = rrq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_RECORD  = rrq_pkg::DEF_MAX_RECORD
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  rrq_pkg::cmd_t                    cmd_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   slot_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rrq_pkg::STATUS_W-1:0]     status_o,
  output logic [rrq_pkg::BYTE_W-1:0]       data_byte_out_o,
  output logic [rrq_pkg::LEN_W-1:0]        record_length_o,
  output logic                             last_out_o
);

  import rrq_pkg::*;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int OFF_W     = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
  localparam int ADDR_W    = PTR_W + OFF_W;
  localparam int MEM_DEPTH = QUEUE_DEPTH * (1 << OFF_W);

  b_state_e          state_q, state_d;
  logic [PTR_W-1:0]  slot_q, slot_d;
  logic [LEN_W-1:0]  n_q, n_d, idx_q, idx_d;

  logic [BYTE_W-1:0] mem_q [MEM_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] raddr, waddr;

  logic              out_valid_q, out_last_q;
  status_e           out_status_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [LEN_W-1:0]  out_len_q;

  logic              out_free, last_byte, is_stream, load, ld_last;
  status_e           ld_status;
  logic [BYTE_W-1:0] ld_byte;
  logic [LEN_W-1:0]  ld_len;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_byte = ((idx_q + LEN_W'(1)) == n_q);
  assign is_stream = (cmd_i.op == CMD_STREAM) && (cmd_i.len != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && out_free && is_stream) begin
          state_d = B_LOAD;
        end
      end
      B_RD: begin
        if (out_free) begin
          state_d = B_LOAD;
        end
      end
      B_LOAD: begin
        state_d = last_byte ? B_IDLE : B_RD;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    raddr     = {slot_q, idx_q[OFF_W-1:0]};
    waddr     = {slot_i, cmd_i.off[OFF_W-1:0]};
    load      = 1'b0;
    ld_status = cmd_i.status;
    ld_byte   = '0;
    ld_len    = cmd_i.len;
    ld_last   = 1'b1;
    slot_d    = slot_q;
    n_d       = n_q;
    idx_d     = idx_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          if (is_stream) begin
            mem_re = 1'b1;
            raddr  = {slot_i, {OFF_W{1'b0}}};
            slot_d = slot_i;
            n_d    = cmd_i.len;
            idx_d  = '0;
          end else begin
            load   = 1'b1;
            mem_we = (cmd_i.op == CMD_WRITE) && cmd_i.we;
          end
        end
      end
      B_RD: begin
        mem_re = out_free;
      end
      B_LOAD: begin
        load      = 1'b1;
        ld_status = ST_OK;
        ld_byte   = rdata_q;
        ld_len    = n_q;
        ld_last   = last_byte;
        idx_d     = idx_q + LEN_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    n_q    <= n_d;
    idx_q  <= idx_d;
    if (load) begin
      out_status_q <= ld_status;
      out_byte_q   <= ld_byte;
      out_len_q    <= ld_len;
      out_last_q   <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign data_byte_out_o = out_byte_q;
  assign record_length_o = out_len_q;
  assign last_out_o      = out_last_q;

endmodule

// ===== sv/record_ring_queue.sv =====
`timescale 1ns / 1ps
// record_ring_queue: ring queue of byte records, top level.
// Instantiates rrq_front, rrq_cmd_fifo and rrq_back; uses rrq_pkg.
//
// Requests enter on the in channel (valid/ready), one byte or command per
// request; results leave on the out channel (valid/ready) from a register.
// Config writes (capacity, record_limit) use their own channel, always ready,
// and must be issued only while the block is idle, which is not enforced.
// Order: a write, clear or error request passes through the command queue and
// is loaded into the output register; a drop first reads the record length
// memory in the front (F_LEN). Pop and read also spend F_LEN in the front on
// the record length memory, then stream the bytes, limited by the registered
// read of the byte memory: each byte is read, then loaded in B_LOAD.
// Throughput: byte writes sustain one request per cycle while the command
// queue has room; pop, read and drop hold in_ready_o low during F_LEN.
// Reset empties the queue and sets capacity 16 and record_limit 64, both
// clamped to the built sizes; record memories start undefined.
// When the receiver stalls the output register holds, the back section
// stops, the four-entry command queue fills and in_ready_o drops.
module record_ring_queue #(
  parameter int QUEUE_DEPTH = rrq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_RECORD  = rrq_pkg::DEF_MAX_RECORD
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rrq_pkg::KIND_W-1:0]       kind_i,
  input  logic [rrq_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                             last_i,
  input  logic [rrq_pkg::IDX_W-1:0]        slot_index_i,
  input  logic [rrq_pkg::LEN_W-1:0]        read_limit_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rrq_pkg::STATUS_W-1:0]     status_o,
  output logic [rrq_pkg::BYTE_W-1:0]       data_byte_out_o,
  output logic [rrq_pkg::LEN_W-1:0]        record_length_o,
  output logic                             last_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rrq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import rrq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CMD_W = PTR_W + $bits(cmd_t);

  logic             push, q_full, q_valid, q_pop;
  cmd_t             f_cmd, b_cmd;
  logic [PTR_W-1:0] f_slot, b_slot;
  logic [CMD_W-1:0] q_out;

  assign cfg_ready_o = 1'b1;

  rrq_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_RECORD (MAX_RECORD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .slot_index_i(slot_index_i),
    .read_limit_i(read_limit_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (f_cmd),
    .slot_o      (f_slot)
  );

  rrq_cmd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_slot, f_cmd}),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_out),
    .pop_i  (q_pop)
  );

  assign b_slot = q_out[CMD_W-1 -: PTR_W];
  assign b_cmd  = cmd_t'(q_out[$bits(cmd_t)-1:0]);

  rrq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_RECORD (MAX_RECORD)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (b_cmd),
    .slot_i         (b_slot),
    .cmd_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .data_byte_out_o(data_byte_out_o),
    .record_length_o(record_length_o),
    .last_out_o     (last_out_o)
  );

endmodule
